@@ sv/r2fft_pkg.sv @@
package r2fft_pkg;

	localparam int VAL_BITS = 23;
	localparam int TW_BITS = 17;
	localparam int LOG2_BITS = 3;
	localparam logic signed [VAL_BITS-1:0] VAL_MAX = 23'sh3FFFFF;
	localparam logic signed [VAL_BITS-1:0] VAL_MIN = 23'sh400000;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_CALC  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic       load_wr;
		logic       bf_rd;
		logic       bf_calc;
		logic       out_rd;
		logic [5:0] rd_a;
		logic [5:0] rd_b;
		logic [5:0] tw_m;
	} cmd_t;

	function automatic logic signed [TW_BITS-1:0] cos_q(input logic [4:0] m);
		logic signed [TW_BITS-1:0] r;
		case (m)
			5'd0: r = 17'sd32768;
			5'd1: r = 17'sd32610;
			5'd2: r = 17'sd32138;
			5'd3: r = 17'sd31357;
			5'd4: r = 17'sd30274;
			5'd5: r = 17'sd28899;
			5'd6: r = 17'sd27246;
			5'd7: r = 17'sd25330;
			5'd8: r = 17'sd23170;
			5'd9: r = 17'sd20788;
			5'd10: r = 17'sd18205;
			5'd11: r = 17'sd15447;
			5'd12: r = 17'sd12540;
			5'd13: r = 17'sd9512;
			5'd14: r = 17'sd6393;
			5'd15: r = 17'sd3212;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [TW_BITS-1:0] cos64(input logic [5:0] m);
		logic signed [TW_BITS-1:0] r;
		if (m <= 6'd16) r = cos_q(m[4:0]);
		else if (m <= 6'd32) r = -cos_q(5'(7'd32 - 7'(m)));
		else if (m <= 6'd48) r = -cos_q(5'(m - 6'd32));
		else r = cos_q(5'(7'd64 - 7'(m)));
		return r;
	endfunction

	function automatic logic signed [VAL_BITS-1:0] sat(input logic signed [VAL_BITS+1:0] v);
		logic signed [VAL_BITS-1:0] r;
		if (v > 25'(VAL_MAX)) r = VAL_MAX;
		else if (v < 25'(VAL_MIN)) r = VAL_MIN;
		else r = v[VAL_BITS-1:0];
		return r;
	endfunction

endpackage

@@ sv/r2fft_ctrl.sv @@
module r2fft_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_data,
	input  logic             in_beat,
	input  logic             out_free,
	output r2fft_pkg::cmd_t  cmd,
	output logic [5:0]       load_addr,
	output logic             in_ready,
	output logic             out_last
);
	r2fft_pkg::state_t state_q;
	logic [2:0] log2_q;
	logic [2:0] lg;
	logic [6:0] cnt_q;
	logic [2:0] stage_q;
	logic [4:0] bf_q;
	logic [6:0] n;
	logic [5:0] half, j, a, base;

	always_comb begin
		lg = log2_q;
		if (lg == 3'd0) lg = 3'd1;
		if (lg == 3'd7) lg = 3'd6;
	end
	assign n = 7'd1 << lg;

	always_comb begin
		load_addr = '0;
		for (int i = 0; i < 6; i++)
			if (i < int'(lg)) load_addr[i] = cnt_q[int'(lg) - 1 - i];
	end

	always_comb begin
		half = 6'd1 << (stage_q - 3'd1);
		j = 6'(bf_q) & (half - 6'd1);
		base = (6'(bf_q) & ~(half - 6'd1)) << 1;
		a = base | j;
	end

	assign in_ready = state_q == r2fft_pkg::ST_LOAD;

	always_comb begin
		cmd = '0;
		cmd.load_wr = in_beat;
		cmd.rd_a = (state_q == r2fft_pkg::ST_EMIT) ? cnt_q[5:0] : a;
		cmd.rd_b = a + half;
		cmd.tw_m = j << (3'd6 - stage_q);
		cmd.bf_rd = state_q == r2fft_pkg::ST_READ;
		cmd.bf_calc = state_q == r2fft_pkg::ST_CALC;
		cmd.out_rd = state_q == r2fft_pkg::ST_EMIT && out_free;
	end
	assign out_last = cnt_q == n - 7'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= r2fft_pkg::ST_LOAD;
			log2_q <= 3'd6;
			cnt_q <= '0;
			stage_q <= 3'd1;
			bf_q <= '0;
		end else if (cfg_we) begin
			log2_q <= cfg_data;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				r2fft_pkg::ST_LOAD: if (in_beat) begin
					if (cnt_q == n - 7'd1) begin
						cnt_q <= '0;
						stage_q <= 3'd1;
						bf_q <= '0;
						state_q <= r2fft_pkg::ST_READ;
					end else cnt_q <= cnt_q + 7'd1;
				end
				r2fft_pkg::ST_READ: state_q <= r2fft_pkg::ST_CALC;
				r2fft_pkg::ST_CALC: begin
					state_q <= r2fft_pkg::ST_READ;
					if (7'(bf_q) == (n >> 1) - 7'd1) begin
						bf_q <= '0;
						if (stage_q == lg) state_q <= r2fft_pkg::ST_EMIT;
						else stage_q <= stage_q + 3'd1;
					end else bf_q <= bf_q + 5'd1;
				end
				r2fft_pkg::ST_EMIT: if (out_free) begin
					if (cnt_q == n - 7'd1) begin
						cnt_q <= '0;
						state_q <= r2fft_pkg::ST_LOAD;
					end else cnt_q <= cnt_q + 7'd1;
				end
				default: state_q <= r2fft_pkg::ST_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n) in_beat |-> in_ready)
		else $error("beat outside load");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == r2fft_pkg::ST_CALC |-> $past(state_q) == r2fft_pkg::ST_READ)
		else $error("calc without read");
endmodule

@@ sv/r2fft_dp.sv @@
module r2fft_dp (
	input  logic                   clk,
	input  r2fft_pkg::cmd_t        cmd,
	input  logic [5:0]             load_addr,
	input  logic signed [15:0]     s_re,
	input  logic signed [15:0]     s_im,
	output logic signed [22:0]     rd_re,
	output logic signed [22:0]     rd_im
);
	logic [45:0] mem [64];
	logic [45:0] da_q, db_q;
	logic [5:0] a_q, b_q, m_q;
	logic signed [16:0] wr, wi;
	logic signed [22:0] br, bi, ur, ui;
	logic signed [40:0] pr, pi;
	logic signed [41:0] tr_f, ti_f;
	logic signed [24:0] tr, ti;

	assign br = db_q[22:0];
	assign bi = db_q[45:23];
	assign ur = da_q[22:0];
	assign ui = da_q[45:23];
	assign wr = r2fft_pkg::cos64(m_q);
	assign wi = -r2fft_pkg::cos64(m_q + 6'd48);
	assign pr = 41'(br) * 41'(wr) - 41'(bi) * 41'(wi);
	assign pi = 41'(br) * 41'(wi) + 41'(bi) * 41'(wr);
	assign tr_f = (42'(pr) + 42'sd16384) >>> 15;
	assign ti_f = (42'(pi) + 42'sd16384) >>> 15;
	assign tr = 25'(tr_f);
	assign ti = 25'(ti_f);
	assign rd_re = da_q[22:0];
	assign rd_im = da_q[45:23];

	always_ff @(posedge clk) begin
		if (cmd.bf_rd || cmd.out_rd) begin
			da_q <= mem[cmd.rd_a];
			a_q <= cmd.rd_a;
		end
		if (cmd.bf_rd) begin
			db_q <= mem[cmd.rd_b];
			b_q <= cmd.rd_b;
			m_q <= cmd.tw_m;
		end
		if (cmd.load_wr)
			mem[load_addr] <= {23'(s_im), 23'(s_re)};
		else if (cmd.bf_calc) begin
			mem[a_q] <= {r2fft_pkg::sat(25'(ui) + ti), r2fft_pkg::sat(25'(ur) + tr)};
			mem[b_q] <= {r2fft_pkg::sat(25'(ui) - ti), r2fft_pkg::sat(25'(ur) - tr)};
		end
	end
endmodule

@@ sv/radix2_fft_engine_top.sv @@
// channel | dir | tdata (low->high)              | tuser | tlast
// s_axis  | in  | sample_real[15:0] imag[31:16]  | -     | -
// m_axis  | out | bin_real[22:0] bin_imag[45:23] | -     | last_bin
// cfg     | in  | log2_points[2:0], write on cfg_we
// Load: samples are written at bit-reversed addresses. Transform: each butterfly
// is a memory read, then compute and write back; N/2*log2(N) butterflies.
// Emit: one bin per free output cycle, memory read into output register.
// Reset clears control only; stalls on m_axis hold the emit counter.
module radix2_fft_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample_real, sample_imag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // bin_real, bin_imag, pad
	output logic        m_axis_tlast
);
	r2fft_pkg::cmd_t cmd;
	logic [5:0] load_addr;
	logic in_ready, out_last, in_beat, out_free;
	logic signed [22:0] rd_re, rd_im;
	logic vld_q, last_q;

	assign in_beat = s_axis_tvalid && in_ready;
	assign s_axis_tready = in_ready;
	assign out_free = !vld_q || m_axis_tready;

	r2fft_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_beat, .out_free,
		.cmd, .load_addr, .in_ready, .out_last
	);
	r2fft_dp u_dp (
		.clk, .cmd, .load_addr,
		.s_re(s_axis_tdata[15:0]), .s_im(s_axis_tdata[31:16]),
		.rd_re, .rd_im
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			last_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= cmd.out_rd;
			last_q <= cmd.out_rd && out_last;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tlast = last_q;
	assign m_axis_tdata = {2'b00, rd_im, rd_re};

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("beat after last bin");
	assert property (@(posedge clk) disable iff (!arst_n) m_axis_tlast |-> m_axis_tvalid)
		else $error("last without valid");
endmodule
